/* design/gmap_pkg.sv */
// Shared constants for the global max / average pooling block.
// Holds parameter defaults, register map codes and register reset values.
// No dependencies.
`default_nettype none

package gmap_pkg;

   // parameter defaults
   localparam int MAX_CHANNELS_DEF = 256;
   localparam int MAX_SEQ_DEF      = 1024;
   localparam int DATA_WIDTH_DEF   = 16;

   // register field widths
   localparam int SEQ_LEN_W   = 11;
   localparam int CHANNELS_W  = 9;
   localparam int RECIP_W     = 17;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;
   localparam int REG_IDX_W   = 2;

   // register indexes (byte address 4*index)
   localparam logic [REG_IDX_W-1:0] REG_SEQ_LEN   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CHANNELS  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RECIP_LEN = 2'd2;

   // register reset values
   localparam logic [SEQ_LEN_W-1:0]  SEQ_LEN_RST   = 11'd1;
   localparam logic [CHANNELS_W-1:0] CHANNELS_RST  = 9'd1;
   localparam logic [RECIP_W-1:0]    RECIP_LEN_RST = 17'd65536;

   // result queue depth: covers the words in flight plus a stalled output
   localparam int FIFO_DEPTH = 8;

   // binary point of the reciprocal
   localparam int RECIP_FRAC = 16;

endpackage

`default_nettype wire

/* design/global_max_avg_pooling.sv */
// A result word passes the stage 1, stage 2 and stage 3 registers and the result queue before it shows on rsp_valid.
// Throughput: one sample word per cycle while req_stall is low; the per-channel read-modify-write
//   of the state memory (one read and one write port, registered read) sets that rate.
// A stalled output backs up into an 8-word result queue; req_stall rises only when
//   the queue plus the words in flight would fill it.
// Reset: row and channel counters clear, registers load 1, 1, 65536. The state
//   memory is not cleared; row 0 of each sequence loads every channel entry in use.
`default_nettype none

module global_max_avg_pooling
   import gmap_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_SEQ      = MAX_SEQ_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   localparam int CHAN_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int ROW_W       = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1
) (
   input  wire                          clock,
   input  wire                          reset,

   // sample stream
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [DATA_WIDTH-1:0]  req_sample,

   // pooled results
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [CHAN_W-1:0]            rsp_channel,
   output logic signed [DATA_WIDTH-1:0] rsp_max_value,
   output logic [ROW_W-1:0]             rsp_max_row,
   output logic signed [DATA_WIDTH-1:0] rsp_average,
   output logic                         rsp_last_channel,

   // configuration
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [PADDR_W-1:0]            paddr,
   input  wire [PDATA_W-1:0]            pwdata,
   output logic [PDATA_W-1:0]           prdata,
   output logic                         pready
);

   // running sum holds MAX_SEQ samples exactly
   localparam int SUM_W  = DATA_WIDTH + $clog2(MAX_SEQ);
   localparam int RCP_W  = RECIP_W + 1;
   localparam int PROD_W = SUM_W + RCP_W;
   localparam int AVG_W  = PROD_W - RECIP_FRAC;
   localparam int FPTR_W = $clog2(FIFO_DEPTH);
   localparam int FCNT_W = FPTR_W + 1;

   localparam logic signed [AVG_W-1:0] AVG_HI =
      AVG_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [AVG_W-1:0] AVG_LO = ~AVG_HI;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] max_value;
      logic [ROW_W-1:0]             best_row;
      logic signed [SUM_W-1:0]      run_sum;
   } entry_type;

   typedef struct packed {
      logic [CHAN_W-1:0]            channel;
      logic signed [DATA_WIDTH-1:0] max_value;
      logic [ROW_W-1:0]             max_row;
      logic signed [DATA_WIDTH-1:0] average;
      logic                         last_channel;
   } result_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [SEQ_LEN_W-1:0]  seq_len_ff;
   logic [CHANNELS_W-1:0] channels_ff;
   logic [RECIP_W-1:0]    recip_len_ff;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  cfg_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[PADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff   <= SEQ_LEN_RST;
         channels_ff  <= CHANNELS_RST;
         recip_len_ff <= RECIP_LEN_RST;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_SEQ_LEN:   seq_len_ff   <= pwdata[SEQ_LEN_W-1:0];
            REG_CHANNELS:  channels_ff  <= pwdata[CHANNELS_W-1:0];
            REG_RECIP_LEN: recip_len_ff <= pwdata[RECIP_W-1:0];
            default: begin
               // writes beyond the map are dropped
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SEQ_LEN:   prdata = PDATA_W'(seq_len_ff);
         REG_CHANNELS:  prdata = PDATA_W'(channels_ff);
         REG_RECIP_LEN: prdata = PDATA_W'(recip_len_ff);
         default:       prdata = '0;
      endcase
   end

   // Last valid row and channel index: zero acts as one, oversize clamps
   // to the store's depth.
   logic [ROW_W-1:0]  row_last;
   logic [CHAN_W-1:0] chan_last;

   always_comb begin
      if (seq_len_ff == '0) begin
         row_last = '0;
      end else if (32'(seq_len_ff) > MAX_SEQ) begin
         row_last = ROW_W'(MAX_SEQ - 1);
      end else begin
         row_last = ROW_W'(32'(seq_len_ff) - 32'd1);
      end
      if (channels_ff == '0) begin
         chan_last = '0;
      end else if (32'(channels_ff) > MAX_CHANNELS) begin
         chan_last = CHAN_W'(MAX_CHANNELS - 1);
      end else begin
         chan_last = CHAN_W'(32'(channels_ff) - 32'd1);
      end
   end

   // ------------------------------------------------------------------
   // Accept stage: row / channel counters and memory read
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   logic [CHAN_W-1:0] chan_count_ff, chan_count_in;
   logic              req_accept;
   logic              is_last_row;
   logic              is_last_ch;

   assign req_accept  = req_valid && !req_stall;
   // a counter left past a lowered limit counts as on the last index
   assign is_last_row = row_count_ff >= row_last;
   assign is_last_ch  = chan_count_ff >= chan_last;

   always_comb begin
      row_count_in  = row_count_ff;
      chan_count_in = chan_count_ff;
      if (req_accept) begin
         if (is_last_ch) begin
            chan_count_in = '0;
            row_count_in  = is_last_row ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            chan_count_in = chan_count_ff + CHAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= '0;
         chan_count_ff <= '0;
      end else begin
         row_count_ff  <= row_count_in;
         chan_count_ff <= chan_count_in;
      end
   end

   // stage 1 registers
   logic                         s1_valid_ff;
   logic [CHAN_W-1:0]            s1_addr_ff;
   logic [ROW_W-1:0]             s1_row_ff;
   logic                         s1_last_row_ff;
   logic                         s1_last_ch_ff;
   logic signed [DATA_WIDTH-1:0] s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff     <= chan_count_ff;
         s1_row_ff      <= row_count_ff;
         s1_last_row_ff <= is_last_row;
         s1_last_ch_ff  <= is_last_ch;
         s1_sample_ff   <= req_sample;
      end
   end

   // ------------------------------------------------------------------
   // State memory: one entry per channel, read-modify-write
   // ------------------------------------------------------------------
   entry_type mem [MAX_CHANNELS];
   entry_type rd_data_ff;
   entry_type wr_data;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_addr_ff] <= wr_data;
      end
      // read returns the old entry on a same-address write; forwarding covers it
      rd_data_ff <= mem[chan_count_ff];
   end

   // Hold the last written entry so a read that raced its write sees it.
   logic              fwd_valid_ff;
   logic [CHAN_W-1:0] fwd_addr_ff;
   entry_type         fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: update max, first row of max and sum
   // ------------------------------------------------------------------
   entry_type                    old_entry;
   logic signed [DATA_WIDTH-1:0] old_max;
   logic signed [SUM_W-1:0]      old_sum;
   logic signed [SUM_W-1:0]      samp_ext;

   assign old_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ?
                      fwd_data_ff : rd_data_ff;
   assign old_max   = old_entry.max_value;
   assign old_sum   = old_entry.run_sum;
   assign samp_ext  = SUM_W'(s1_sample_ff);

   always_comb begin
      wr_data = old_entry;
      if (s1_row_ff == '0) begin
         // first row of a sequence loads the entry
         wr_data.max_value = s1_sample_ff;
         wr_data.best_row  = '0;
         wr_data.run_sum   = samp_ext;
      end else begin
         // strict compare: the earliest row keeps a tie
         if (s1_sample_ff > old_max) begin
            wr_data.max_value = s1_sample_ff;
            wr_data.best_row  = s1_row_ff;
         end
         wr_data.run_sum = old_sum + samp_ext;
      end
   end

   // stage 2: only last-row words go on
   logic                         s2_valid_ff;
   logic [CHAN_W-1:0]            s2_channel_ff;
   logic signed [DATA_WIDTH-1:0] s2_max_ff;
   logic [ROW_W-1:0]             s2_row_ff;
   logic signed [SUM_W-1:0]      s2_sum_ff;
   logic                         s2_last_ch_ff;
   logic                         s1_emit;

   assign s1_emit = s1_valid_ff && s1_last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit) begin
         s2_channel_ff <= s1_addr_ff;
         s2_max_ff     <= wr_data.max_value;
         s2_row_ff     <= wr_data.best_row;
         s2_sum_ff     <= wr_data.run_sum;
         s2_last_ch_ff <= s1_last_ch_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: sum times reciprocal
   // ------------------------------------------------------------------
   logic                         s3_valid_ff;
   logic [CHAN_W-1:0]            s3_channel_ff;
   logic signed [DATA_WIDTH-1:0] s3_max_ff;
   logic [ROW_W-1:0]             s3_row_ff;
   logic signed [PROD_W-1:0]     s3_prod_ff, s3_prod_in;
   logic                         s3_last_ch_ff;

   assign s3_prod_in = PROD_W'(s2_sum_ff) * PROD_W'($signed({1'b0, recip_len_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_channel_ff <= s2_channel_ff;
         s3_max_ff     <= s2_max_ff;
         s3_row_ff     <= s2_row_ff;
         s3_prod_ff    <= s3_prod_in;
         s3_last_ch_ff <= s2_last_ch_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: floor shift, saturate, push into the result queue
   // ------------------------------------------------------------------
   logic signed [AVG_W-1:0]      avg_wide;
   logic signed [DATA_WIDTH-1:0] avg_sat;
   result_type                   push_word;

   // dropping the fraction bits of a signed value floors it
   assign avg_wide = s3_prod_ff[PROD_W-1:RECIP_FRAC];

   always_comb begin
      if (avg_wide > AVG_HI) begin
         avg_sat = AVG_HI[DATA_WIDTH-1:0];
      end else if (avg_wide < AVG_LO) begin
         avg_sat = AVG_LO[DATA_WIDTH-1:0];
      end else begin
         avg_sat = avg_wide[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      push_word.channel      = s3_channel_ff;
      push_word.max_value    = s3_max_ff;
      push_word.max_row      = s3_row_ff;
      push_word.average      = avg_sat;
      push_word.last_channel = s3_last_ch_ff;
   end

   result_type        fifo [FIFO_DEPTH];
   logic [FPTR_W-1:0] wr_ptr_ff;
   logic [FPTR_W-1:0] rd_ptr_ff;
   logic [FCNT_W-1:0] fifo_count_ff, fifo_count_in;
   logic              fifo_pop;
   logic [FCNT_W-1:0] pending;
   result_type        head_word;

   assign fifo_pop = rsp_valid && !rsp_stall;

   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (s3_valid_ff && !fifo_pop) begin
         fifo_count_in = fifo_count_ff + FCNT_W'(1);
      end else if (!s3_valid_ff && fifo_pop) begin
         fifo_count_in = fifo_count_ff - FCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FPTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FPTR_W'(1);
         end
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         fifo[wr_ptr_ff] <= push_word;
      end
   end

   // Reserve queue space for every word already in flight.
   assign pending = fifo_count_ff + FCNT_W'(s1_emit) + FCNT_W'(s2_valid_ff)
                  + FCNT_W'(s3_valid_ff);
   assign req_stall = pending >= FCNT_W'(FIFO_DEPTH);

   assign head_word        = fifo[rd_ptr_ff];
   assign rsp_valid        = fifo_count_ff != '0;
   assign rsp_channel      = head_word.channel;
   assign rsp_max_value    = head_word.max_value;
   assign rsp_max_row      = head_word.max_row;
   assign rsp_average      = head_word.average;
   assign rsp_last_channel = head_word.last_channel;

`ifndef ASSERT_OFF
   // queue never overflows, in-flight words included
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= FCNT_W'(FIFO_DEPTH))
      else $error("result queue credit exceeded");

   // a last-row update reaches the multiply stage next cycle
   a_emit_flow: assert property (@(posedge clock) disable iff (reset)
      s1_emit |=> s2_valid_ff)
      else $error("last-row word lost after update stage");

   // end of a sequence wraps both counters
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_last_row && is_last_ch |=> row_count_ff == '0 && chan_count_ff == '0)
      else $error("counters did not wrap at end of sequence");

   // a queue push comes from a last-row update carried through the stage 2 and stage 3 registers
   a_push_timing: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> $past(s1_emit, 2))
      else $error("queue push without matching update");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for global_max_avg_pooling: streams signed Q8.8 sample words, reprograms
// the pooling registers between bursts and scores each pooled word against a local model.
// Depends on gmap_pkg and the global_max_avg_pooling RTL.

module tb;
   import gmap_pkg::*;

   localparam int CHAN_BITS    = $clog2(MAX_CHANNELS_DEF);
   localparam int ROW_BITS     = $clog2(MAX_SEQ_DEF);
   localparam int DW           = DATA_WIDTH_DEF;
   localparam int LAT_PAD      = 12;       // margin past the output pipeline
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_WORDS = 1650;
   localparam int PHASE_CAP    = 300;      // longest well-formed burst
   localparam int LONG_HOLD    = 80;       // receiver hold-off that backs up the queue

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic signed [DW-1:0] max_value;
      logic [ROW_BITS-1:0]  max_row;
      logic signed [DW-1:0] average;
      logic                 last_channel;
   } pooled_type;

   // Shadow copy of the pooling state; queues the pooled word each last-row sample should produce.
   class pooling_shadow;
      int unsigned          rows_reg, width_reg, recip_reg;
      logic signed [DW-1:0] peak [MAX_CHANNELS_DEF];
      longint               total [MAX_CHANNELS_DEF];
      int                   peak_row [MAX_CHANNELS_DEF];
      bit                   loaded [MAX_CHANNELS_DEF];
      int                   row_ctr, chan_ctr;
      pooled_type           pending_pools [$];
      int                   fails;

      function new();
         rows_reg  = SEQ_LEN_RST;
         width_reg = CHANNELS_RST;
         recip_reg = RECIP_LEN_RST;
         row_ctr   = 0;
         chan_ctr  = 0;
         fails     = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      // zero acts as one, oversized acts as the maximum
      function int clamp_dim(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
         case (idx)
            REG_SEQ_LEN:   rows_reg  = value[SEQ_LEN_W-1:0];
            REG_CHANNELS:  width_reg = value[CHANNELS_W-1:0];
            REG_RECIP_LEN: recip_reg = value[RECIP_W-1:0];
            default: ;
         endcase
      endfunction

      // widest channel setting that only reads entries row 0 loaded in this sequence
      function int safe_width();
         int n;
         if (row_ctr == 0) return MAX_CHANNELS_DEF;
         n = 0;
         while (n < MAX_CHANNELS_DEF && loaded[n]) n++;
         return n;
      endfunction

      function void take_sample(logic signed [DW-1:0] s);
         int         len, wid, r, c;
         bit         last_row, last_ch;
         longint     avg, hi;
         pooled_type res;
         len = clamp_dim(rows_reg, MAX_SEQ_DEF);
         wid = clamp_dim(width_reg, MAX_CHANNELS_DEF);
         r = row_ctr;
         c = (chan_ctr >= MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF - 1 : chan_ctr;
         last_row = r >= len - 1;
         last_ch  = c >= wid - 1;
         if (r == 0) begin
            peak[c]     = s;
            peak_row[c] = 0;
            total[c]    = s;
            loaded[c]   = 1'b1;
         end else begin
            if (s > peak[c]) begin
               peak[c]     = s;
               peak_row[c] = r;
            end
            total[c] += s;
         end
         if (last_row) begin
            hi  = (longint'(1) << (DW - 1)) - 1;
            avg = (total[c] * longint'(recip_reg)) >>> RECIP_FRAC;
            if (avg > hi) avg = hi;
            if (avg < -hi - 1) avg = -hi - 1;
            res.channel      = CHAN_BITS'(c);
            res.max_value    = peak[c];
            res.max_row      = ROW_BITS'(peak_row[c]);
            res.average      = DW'(avg);
            res.last_channel = last_ch;
            pending_pools.push_back(res);
         end
         if (last_ch) begin
            chan_ctr = 0;
            if (last_row) begin
               row_ctr = 0;
               foreach (loaded[i]) loaded[i] = 1'b0;
            end else begin
               row_ctr = r + 1;
            end
         end else begin
            chan_ctr = c + 1;
         end
      endfunction

      task report(string what);
         fails++;
         if (fails <= 100) $display("mismatch at %0t: %s", $time, what);
      endtask

      task match_pool(pooled_type got);
         pooled_type want;
         if (pending_pools.size() == 0) begin
            report($sformatf("unexpected pooled word for channel %0d", got.channel));
            return;
         end
         want = pending_pools.pop_front();
         if (got !== want)
            report($sformatf({"got/want ch %0d/%0d max %0d/%0d row %0d/%0d",
                              " avg %0d/%0d last %0d/%0d"},
                             got.channel, want.channel, got.max_value, want.max_value,
                             got.max_row, want.max_row, got.average, want.average,
                             got.last_channel, want.last_channel));
      endtask
   endclass

   logic                  clock, reset;
   logic                  req_valid, req_stall;
   logic signed [DW-1:0]  req_sample;
   logic                  rsp_valid, rsp_stall;
   logic [CHAN_BITS-1:0]  rsp_channel;
   logic signed [DW-1:0]  rsp_max_value, rsp_average;
   logic [ROW_BITS-1:0]   rsp_max_row;
   logic                  rsp_last_channel;
   logic                  psel, penable, pwrite, pready;
   logic [PADDR_W-1:0]    paddr;
   logic [PDATA_W-1:0]    pwdata, prdata;

   pooling_shadow sb;
   int  cycle_count = 0;
   int  stall_left  = 0;
   bit  hold_req    = 1'b0;   // ask the receiver for one long hold-off
   bit  calm        = 1'b1;   // no random gaps on either side while set

   global_max_avg_pooling u_dut (.*);

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run; a hang anywhere lands here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return $urandom_range(1, 3);
      if (p < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mix full-range values, tie-prone small values and the extremes.
   function automatic logic signed [DW-1:0] draw_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p < 5) return DW'($urandom);
      if (p < 8) return DW'(int'($urandom_range(0, 6)) - 3);
      case ($urandom_range(0, 3))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh7FFE;
         default: return 16'sh8001;
      endcase
   endfunction

   // Sometimes put junk above the register field; the block keeps only the field.
   function automatic logic [PDATA_W-1:0] with_junk(int unsigned v, int w);
      if ($urandom_range(0, 4) == 0) return ($urandom << w) | v;
      return v;
   endfunction

   // Receiver: one stall decision per edge. A pending long hold-off takes priority
   // over the random gaps; count it down here so the sender keeps offering words.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req   = 1'b0;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left = gap_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Score every pooled word taken at this edge (pre-edge values are read here).
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_pool(pooled_type'({rsp_channel, rsp_max_value, rsp_max_row,
                                     rsp_average, rsp_last_channel}));

   // Offer one sample word, after an optional gap, and hold it until taken.
   task automatic send_sample(logic signed [DW-1:0] v);
      int gap;
      gap = (calm || $urandom_range(0, 9) > 2) ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (req_stall);
      sb.take_sample(v);
   endtask

   // Drop valid, wait for every expected word, then let the pipeline empty out,
   // since rows before the last one leave work in flight with nothing expected.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_pools.size() != 0) @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then idle with psel low so writes never share a step.
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   initial begin
      int                   n, len, wid, rem, picks, p, val, sent;
      logic signed [DW-1:0] v;
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      rsp_stall  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      calm = 1'b0;

      // Reset settings pool each word alone: average equals the value.
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      settle();

      // Zero length and width act as one; zero reciprocal zeroes the average.
      write_reg(REG_SEQ_LEN, 0);
      write_reg(REG_CHANNELS, 0);
      write_reg(REG_RECIP_LEN, 0);
      send_sample(16'sd5);
      send_sample(-16'sd5);
      settle();

      // Ties: channel 0 repeats its max (earliest row wins), channel 1 peaks at row 1.
      write_reg(REG_SEQ_LEN, 3);
      write_reg(REG_CHANNELS, 2);
      write_reg(REG_RECIP_LEN, 21845);
      send_sample(16'sd7);
      send_sample(-16'sd3);
      send_sample(16'sd7);
      send_sample(16'sd4);
      send_sample(16'sd7);
      send_sample(16'sd4);
      settle();

      // Reciprocal above one: the average saturates both ways.
      write_reg(REG_SEQ_LEN, 2);
      write_reg(REG_CHANNELS, 1);
      write_reg(REG_RECIP_LEN, 131071);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      settle();

      // Oversized length and width, then shrink both under the live counters.
      write_reg(REG_SEQ_LEN, 2047);
      write_reg(REG_CHANNELS, 300);
      repeat (5) send_sample(draw_sample());
      settle();
      write_reg(REG_CHANNELS, 2);
      send_sample(draw_sample());
      settle();
      write_reg(REG_SEQ_LEN, 1);
      write_reg(REG_RECIP_LEN, 32768);
      send_sample(draw_sample());
      send_sample(draw_sample());
      settle();

      // One full-length sequence; the single top value lands on the last row.
      write_reg(REG_SEQ_LEN, $urandom_range(0, 1) ? 1024 : 2047);
      write_reg(REG_CHANNELS, 1);
      write_reg(REG_RECIP_LEN, 64);
      repeat (MAX_SEQ_DEF - 1) begin
         v = draw_sample();
         if (v == 16'sh7FFF) v = 16'sh7FFE;
         send_sample(v);
      end
      send_sample(16'sh7FFF);
      settle();
      sent = MAX_SEQ_DEF;

      // Back up the result queue: long receiver hold-off, sender offering every cycle.
      write_reg(REG_SEQ_LEN, 1);
      write_reg(REG_CHANNELS, 3);
      calm     = 1'b1;
      hold_req = 1'b1;
      repeat (40) send_sample(draw_sample());
      settle();
      sent += 40;

      // Random bursts: new settings each time, mostly whole sequences, some cut short.
      while (sent < RANDOM_WORDS) begin
         picks = $urandom_range(1, 7);
         if (picks[0]) begin
            p = $urandom_range(0, 99);
            if (p < 8)       val = 0;
            else if (p < 20) val = 1;
            else if (p < 65) val = $urandom_range(2, 6);
            else if (p < 88) val = $urandom_range(7, 24);
            else if (p < 96) val = $urandom_range(25, 64);
            else             val = $urandom_range(1025, 2047);
            write_reg(REG_SEQ_LEN, with_junk(val, SEQ_LEN_W));
         end
         if (picks[1]) begin
            p = $urandom_range(0, 99);
            if (p < 8)       val = 0;
            else if (p < 25) val = 1;
            else if (p < 75) val = $urandom_range(2, 8);
            else if (p < 93) val = $urandom_range(9, 32);
            else             val = $urandom_range(256, 511);
            // never widen past what row 0 loaded in a sequence under way
            if (sb.clamp_dim(val, MAX_CHANNELS_DEF) > sb.safe_width())
               val = $urandom_range(1, sb.safe_width());
            write_reg(REG_CHANNELS, with_junk(val, CHANNELS_W));
         end
         len = sb.clamp_dim(sb.rows_reg, MAX_SEQ_DEF);
         wid = sb.clamp_dim(sb.width_reg, MAX_CHANNELS_DEF);
         if (picks[2]) begin
            p = $urandom_range(0, 99);
            if (p < 50)      val = (65536 + len / 2) / len;
            else if (p < 70) val = $urandom_range(0, 131071);
            else if (p < 78) val = 0;
            else if (p < 86) val = 65536;
            else if (p < 92) val = 131071;
            else             val = $urandom_range(60000, 70000);
            write_reg(REG_RECIP_LEN, with_junk(val, RECIP_W));
         end

         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) hold_req = 1'b1;

         // finish the sequence under way plus a few whole ones, or cut it anywhere
         n = 0;
         if ($urandom_range(0, 9) < 7 && sb.row_ctr < len && sb.chan_ctr < wid) begin
            rem = len * wid - (sb.row_ctr * wid + sb.chan_ctr);
            n = rem + $urandom_range(0, 3) * len * wid;
         end
         if (n <= 0 || n > PHASE_CAP) n = $urandom_range(1, 40);
         repeat (n) send_sample(draw_sample());
         sent += n;
         settle();
      end

      if (sb.fails == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
